// ----- design/ifhg_pkg.sv -----
// ----------------------------------------------------------------------------
// ifhg_pkg
// Shared constants and types of the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
package ifhg_pkg;

    localparam int HEADER_BYTES  = 20;
    localparam int MAX_FRAGMENTS = 64;

    localparam int MTU_W   = 11;
    localparam int ADDR_W  = 32;
    localparam int ID_W    = 16;
    localparam int LEN_W   = 16;
    localparam int PROTO_W = 8;
    localparam int OFF_W   = 13;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MTU_W-1:0] MTU_LOW   = 11'd1044;
    localparam logic [MTU_W-1:0] MTU_HIGH  = 11'd1500;
    localparam logic [MTU_W-1:0] MTU_RESET = 11'd1500;
    localparam logic [MTU_W-1:0] HDR_LEN   = MTU_W'(HEADER_BYTES);
    localparam logic [ID_W-1:0]  ID_RESET  = 16'd1;

    // version 4, IHL in 32-bit words, TOS 0
    localparam logic [WORD_W-1:0] VERSION_WORD =
        WORD_W'((4 << 12) | ((HEADER_BYTES / 4) << 8));
    localparam logic [7:0] TTL_VALUE = 8'h80;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAX_FRAGMENTS - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MTU   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT = 2'd3;

    typedef struct packed {
        logic [MTU_W-1:0]  mtu;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [ID_W-1:0]   ident;
    } t_cfg;

endpackage

// ----- design/ipv4_fragment_header_generator.sv -----
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator
// Splits a payload into IPv4 fragments and emits one header descriptor,
// with checksum, per fragment.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes a payload length and a
//   protocol number. Output channel (o_out_valid / i_out_stall) gives one
//   descriptor beat per fragment, in order, the final beat flagged last.
//   A beat moves when valid is high and stall is low.
//   Configuration (mtu, source, destination, identification) is written
//   through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
//   Sequence: after a request is taken, the sequencer folds the fixed header
//   words through the shared one's complement adder; each fragment then
//   passes through size, two checksum adds and emit, and the next fragment
//   starts only once the emit step has loaded the previous beat.
//   o_in_stall is high from acceptance until the last beat is loaded into
//   the output register. A zero length produces no beat.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer waits in its emit step.
//   Reset restores the register defaults (mtu 1500, identification 1,
//   addresses 0) and drops any request in flight.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ifhg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ifhg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ifhg_pkg::LEN_W-1:0]      i_payload_length,
    input  logic [ifhg_pkg::PROTO_W-1:0]    i_upper_protocol,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ifhg_pkg::MTU_W-1:0]      o_total_length,
    output logic                            o_more_fragments,
    output logic [ifhg_pkg::OFF_W-1:0]      o_frag_offset_units,
    output logic [ifhg_pkg::LEN_W-1:0]      o_payload_start,
    output logic [ifhg_pkg::WORD_W-1:0]     o_header_sum,
    output logic                            o_last_fragment
);
    import ifhg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mtu   <= MTU_RESET;
            r_cfg.src   <= '0;
            r_cfg.dst   <= '0;
            r_cfg.ident <= ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MTU:   r_cfg.mtu   <= i_cfg_data[MTU_W-1:0];
                CFG_SRC:   r_cfg.src   <= i_cfg_data[ADDR_W-1:0];
                CFG_DST:   r_cfg.dst   <= i_cfg_data[ADDR_W-1:0];
                CFG_IDENT: r_cfg.ident <= i_cfg_data[ID_W-1:0];
                default:   r_cfg.mtu   <= r_cfg.mtu;
            endcase
        end
    end

    ifhg_frag_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_payload_length    (i_payload_length),
        .i_upper_protocol    (i_upper_protocol),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_total_length      (o_total_length),
        .o_more_fragments    (o_more_fragments),
        .o_frag_offset_units (o_frag_offset_units),
        .o_payload_start     (o_payload_start),
        .o_header_sum        (o_header_sum),
        .o_last_fragment     (o_last_fragment)
    );

endmodule

// ----- design/ifhg_oc_add.sv -----
// ----------------------------------------------------------------------------
// ifhg_oc_add
// One's complement 16-bit adder with end-around carry, shared by all
// checksum steps.
// ----------------------------------------------------------------------------
module ifhg_oc_add (
    input  logic [ifhg_pkg::WORD_W-1:0] i_a,
    input  logic [ifhg_pkg::WORD_W-1:0] i_b,
    output logic [ifhg_pkg::WORD_W-1:0] o_sum
);
    import ifhg_pkg::*;

    logic [WORD_W:0] raw;

    assign raw   = {1'b0, i_a} + {1'b0, i_b};
    // wrap the carry back in; a second carry cannot occur
    assign o_sum = raw[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw[WORD_W]};

endmodule

// ----- design/ifhg_frag_seq.sv -----
// ----------------------------------------------------------------------------
// ifhg_frag_seq
// Sequencer: folds the fixed header words once per request, then walks the
// fragments, adding the per-fragment words through the shared adder.
// ----------------------------------------------------------------------------
module ifhg_frag_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ifhg_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ifhg_pkg::LEN_W-1:0]    i_payload_length,
    input  logic [ifhg_pkg::PROTO_W-1:0]  i_upper_protocol,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ifhg_pkg::MTU_W-1:0]    o_total_length,
    output logic                          o_more_fragments,
    output logic [ifhg_pkg::OFF_W-1:0]    o_frag_offset_units,
    output logic [ifhg_pkg::LEN_W-1:0]    o_payload_start,
    output logic [ifhg_pkg::WORD_W-1:0]   o_header_sum,
    output logic                          o_last_fragment
);
    import ifhg_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BASE = 6'b000010,
        S_FRAG = 6'b000100,
        S_SUM1 = 6'b001000,
        S_SUM2 = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    localparam logic [2:0] BASE_LAST_STEP = 3'd5;

    t_state             r_state, n_state;
    logic [2:0]         r_step;
    logic [IDX_W-1:0]   r_frag_idx;
    logic [LEN_W-1:0]   r_bytes_left;
    logic [PROTO_W-1:0] r_active_proto;
    logic [LEN_W-1:0]   r_start;
    logic [MTU_W-1:0]   r_mtu;
    logic [MTU_W-1:0]   r_frag;
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_base;
    logic [MTU_W-1:0]   r_tlen;
    logic               r_more;
    logic               r_last;
    logic               r_out_valid;

    logic               accept;
    logic               load_out;
    logic [MTU_W-1:0]   mtu_sat;
    logic [WORD_W-1:0]  add_a, add_b, add_sum;
    logic               more_now;
    logic [LEN_W-1:0]   frag_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign load_out   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign frag_ext   = {{(LEN_W-MTU_W){1'b0}}, r_frag};
    assign more_now   = r_bytes_left > frag_ext;

    always_comb begin
        if (i_cfg.mtu < MTU_LOW) begin
            mtu_sat = MTU_LOW;
        end else if (i_cfg.mtu > MTU_HIGH) begin
            mtu_sat = MTU_HIGH;
        end else begin
            mtu_sat = i_cfg.mtu;
        end
    end

    // operand select for the shared adder
    always_comb begin
        add_a = r_acc;
        add_b = '0;
        case (r_state)
            S_BASE: begin
                case (r_step)
                    3'd0:    add_b = i_cfg.ident;
                    3'd1:    add_b = {TTL_VALUE, r_active_proto};
                    3'd2:    add_b = i_cfg.src[ADDR_W-1:WORD_W];
                    3'd3:    add_b = i_cfg.src[WORD_W-1:0];
                    3'd4:    add_b = i_cfg.dst[ADDR_W-1:WORD_W];
                    default: add_b = i_cfg.dst[WORD_W-1:0];
                endcase
            end
            S_SUM1:  add_b = {{(WORD_W-MTU_W){1'b0}}, r_tlen};
            S_SUM2:  add_b = {2'b00, r_more, r_start[LEN_W-1:3]};
            default: add_b = '0;
        endcase
    end

    ifhg_oc_add u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_payload_length != '0)) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (r_step == BASE_LAST_STEP) begin
                    n_state = S_FRAG;
                end
            end
            S_FRAG:  n_state = S_SUM1;
            S_SUM1:  n_state = S_SUM2;
            S_SUM2:  n_state = S_EMIT;
            S_EMIT: begin
                if (load_out) begin
                    n_state = r_last ? S_IDLE : S_FRAG;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_frag_idx     <= '0;
            r_bytes_left   <= '0;
            r_active_proto <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_frag_idx     <= '0;
                r_bytes_left   <= i_payload_length;
                r_active_proto <= i_upper_protocol;
            end else if (load_out) begin
                r_frag_idx   <= r_frag_idx + 1'b1;
                r_bytes_left <= r_more ? (r_bytes_left - frag_ext) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mtu   <= mtu_sat;
                r_frag  <= mtu_sat - HDR_LEN;
                r_start <= '0;
                r_acc   <= VERSION_WORD;
                r_step  <= '0;
            end
            S_BASE: begin
                r_acc  <= add_sum;
                r_base <= add_sum;
                r_step <= r_step + 1'b1;
            end
            S_FRAG: begin
                r_acc  <= r_base;
                r_more <= more_now;
                r_last <= !more_now || (r_frag_idx == LAST_INDEX);
                r_tlen <= more_now ? r_mtu : (r_bytes_left[MTU_W-1:0] + HDR_LEN);
            end
            S_SUM1, S_SUM2: begin
                r_acc <= add_sum;
            end
            S_EMIT: begin
                if (load_out) begin
                    r_start <= r_start + frag_ext;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // output register; hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_total_length      <= r_tlen;
            o_more_fragments    <= r_more;
            o_frag_offset_units <= r_start[LEN_W-1:3];
            o_payload_start     <= r_start;
            o_header_sum        <= ~r_acc;
            o_last_fragment     <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_last) |=> (r_state == S_IDLE))
        else $error("sequencer kept going after the last fragment");

    a_no_empty_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAG) |-> (r_bytes_left != '0))
        else $error("fragment started with no bytes left");

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_more_fragments) |-> o_last_fragment)
        else $error("final fragment not marked last");
`endif

endmodule
